[hw/rtl/erol_pkg.sv]
package erol_pkg;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_FIND = 1'b1;

  localparam logic [1:0] STAT_ADDED = 2'd0;
  localparam logic [1:0] STAT_FOUND = 2'd1;
  localparam logic [1:0] STAT_MISS  = 2'd2;

  typedef struct packed {
    logic        func;
    logic [31:0] entry_handle;
    logic [15:0] entry_size;
    logic [19:0] byte_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_handle;
    logic [15:0] found_size;
    logic [3:0]  found_slot;
    logic [15:0] byte_in_entry;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_PRIME,
    ST_WALK
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic walk_init;
    logic do_add;
    logic advance;
    logic accumulate;
    logic emit_add;
    logic emit_found;
    logic emit_miss;
  } ctl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic cnt_zero;
    logic hit;
    logic last;
  } dp_stat_t;

endpackage

[hw/rtl/erol_ram.sv]
module erol_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/erol_ctrl.sv]
module erol_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              func,
  input  erol_pkg::dp_stat_t stat,
  output erol_pkg::ctl_cmd_t cmd,
  output logic              busy
);

  import erol_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (func == FUNC_ADD) begin
            state_nxt = ST_ADD;
          end else if (!stat.cnt_zero) begin
            state_nxt = ST_PRIME;
          end
        end
      end
      ST_ADD:   state_nxt = ST_IDLE;
      ST_PRIME: state_nxt = ST_WALK;
      ST_WALK: begin
        if (stat.hit || stat.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (func == FUNC_FIND) begin
            // An empty ring answers at once without walking.
            cmd.walk_init = 1'b1;
            cmd.emit_miss = stat.cnt_zero;
          end
        end
      end
      ST_ADD: begin
        cmd.do_add   = 1'b1;
        cmd.emit_add = 1'b1;
      end
      ST_PRIME: begin
        cmd.advance = 1'b1;
      end
      ST_WALK: begin
        if (stat.hit) begin
          cmd.emit_found = 1'b1;
        end else if (stat.last) begin
          cmd.emit_miss = 1'b1;
        end else begin
          cmd.advance    = 1'b1;
          cmd.accumulate = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

[hw/rtl/erol_dp.sv]
module erol_dp #(
  parameter int DEPTH = 16,
  parameter int SW    = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  erol_pkg::req_t     req,
  input  erol_pkg::ctl_cmd_t cmd,
  output erol_pkg::dp_stat_t stat,
  output erol_pkg::res_t     res,
  output logic               strobe
);

  import erol_pkg::*;

  localparam int PW  = $clog2(DEPTH);
  localparam int AW  = SW + PW + 1;
  localparam int CW  = ((AW > 20) ? AW : 20) + 1;
  localparam int SLW = (PW > 4) ? PW : 4;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic          full_r, full_nxt;
  logic [PW-1:0] pos_r, pos_nxt, chk_r, chk_nxt;
  logic [PW:0]   left_r, left_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic [19:0]   off_r;
  logic [31:0]   hdl_r;
  logic [SW-1:0] sz_r;
  res_t          res_r, res_nxt;
  logic          strobe_r;

  logic [PW:0]      cnt;
  logic [PW:0]      diff;
  logic [31+SW:0]   rdata;
  logic [31:0]      rd_hdl;
  logic [SW-1:0]    rd_sz;
  logic [CW-1:0]    cmp_off, cmp_end, in_pos;
  logic [SLW-1:0]   slot_ext;
  logic [PW-1:0]    wp_inc;

  erol_ram #(
    .WIDTH (32 + SW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.do_add),
    .waddr (wp_r),
    .wdata ({hdl_r, sz_r}),
    .raddr (pos_r),
    .rdata (rdata)
  );

  assign rd_hdl = rdata[31+SW:SW];
  assign rd_sz  = rdata[SW-1:0];

  always_comb begin
    diff = {1'b0, wp_r} - {1'b0, rp_r};
    if (full_r) begin
      cnt = (PW+1)'(DEPTH);
    end else if (wp_r < rp_r) begin
      cnt = diff + (PW+1)'(DEPTH);
    end else begin
      cnt = diff;
    end
  end

  assign cmp_off  = CW'(off_r);
  assign cmp_end  = CW'(acc_r) + CW'(rd_sz);
  assign in_pos   = cmp_off - CW'(acc_r);
  assign slot_ext = SLW'(chk_r);

  assign stat.cnt_zero = (cnt == '0);
  assign stat.hit      = (cmp_off < cmp_end);
  assign stat.last     = (left_r == (PW+1)'(1));

  assign wp_inc = ptr_inc(wp_r);

  always_comb begin
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    full_nxt = full_r;
    if (cmd.do_add) begin
      wp_nxt = wp_inc;
      if (full_r) begin
        rp_nxt = ptr_inc(rp_r);
      end else if (wp_inc == rp_r) begin
        full_nxt = 1'b1;
      end
    end
  end

  // The read address runs one entry ahead of the entry being checked,
  // since the RAM registers its read data.
  always_comb begin
    pos_nxt  = pos_r;
    chk_nxt  = chk_r;
    left_nxt = left_r;
    acc_nxt  = acc_r;
    if (cmd.walk_init) begin
      pos_nxt  = rp_r;
      left_nxt = cnt;
      acc_nxt  = '0;
    end
    if (cmd.advance) begin
      pos_nxt = ptr_inc(pos_r);
      chk_nxt = pos_r;
    end
    if (cmd.accumulate) begin
      left_nxt = left_r - (PW+1)'(1);
      acc_nxt  = acc_r + AW'(rd_sz);
    end
  end

  always_comb begin
    res_nxt = res_r;
    if (cmd.emit_add) begin
      res_nxt        = '0;
      res_nxt.status = STAT_ADDED;
    end else if (cmd.emit_miss) begin
      res_nxt        = '0;
      res_nxt.status = STAT_MISS;
    end else if (cmd.emit_found) begin
      res_nxt.status        = STAT_FOUND;
      res_nxt.found_handle  = rd_hdl;
      res_nxt.found_size    = 16'(rd_sz);
      res_nxt.found_slot    = slot_ext[3:0];
      res_nxt.byte_in_entry = in_pos[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      rp_r     <= '0;
      full_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      full_r   <= full_nxt;
      strobe_r <= cmd.emit_add | cmd.emit_miss | cmd.emit_found;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    chk_r  <= chk_nxt;
    left_r <= left_nxt;
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
    if (cmd.load) begin
      off_r <= req.byte_offset;
      hdl_r <= req.entry_handle;
      sz_r  <= req.entry_size[SW-1:0];
    end
  end

  assign res    = res_r;
  assign strobe = strobe_r;

endmodule

[hw/rtl/entry_ring_offset_locator.sv]
// Overwriting ring of DEPTH entries (handle and byte size) with a lookup
// that maps a byte offset in the concatenated entries to the entry holding it.
// A request is taken at a clock edge where start is high and busy is low;
// in_data carries the operation and its fields. Each request gives one
// result on out_res, marked by out_strobe for exactly one cycle; the
// receiver always takes it and cannot stall the block.
// An add writes the slot at the write pointer and drops the oldest entry
// when the ring is full; its result is registered from the ST_ADD state, and
// busy stays high in ST_ADD, so no next request is taken until the add is done.
// A find walks the stored entries oldest first, one per cycle through the
// slot RAM read port, from ST_PRIME into ST_WALK until a hit or the last
// stored entry, and the result register loads as the walk ends. A find on an
// empty ring skips the walk and answers in the cycle after acceptance. busy
// is low in the cycle the result is shown, so a new request may be taken then.
// Sizes are kept in the low min(SIZE_BITS, 16) bits.
// Reset empties the ring; slot contents stay as they were and are only
// read once written.
module entry_ring_offset_locator #(
  parameter int DEPTH     = 16,
  parameter int SIZE_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  erol_pkg::req_t in_data,
  output logic           out_strobe,
  output erol_pkg::res_t out_res
);

  import erol_pkg::*;

  localparam int SW = (SIZE_BITS < 16) ? SIZE_BITS : 16;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  erol_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_data.func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  erol_dp #(
    .DEPTH (DEPTH),
    .SW    (SW)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (in_data),
    .cmd    (cmd),
    .stat   (stat),
    .res    (out_res),
    .strobe (out_strobe)
  );

endmodule
